FILE: rtl/pptb_pkg.sv
`default_nettype none

package pptb_pkg;

    localparam int TEX_MAX_W = 64;
    localparam int TEX_MAX_H = 64;
    localparam int TEX_BYTES = 4096;
    localparam int ADDR_W    = $clog2(TEX_BYTES);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_ROW   = 2'd2;

    localparam logic [2:0] KIND_PIXEL    = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED = 3'd1;
    localparam logic [2:0] KIND_REJECTED = 3'd2;
    localparam logic [2:0] KIND_EMPTY    = 3'd3;
    localparam logic [2:0] KIND_FINISHED = 3'd4;

    localparam logic [2:0] CFG_TEX_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_TEX_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_BPP_LOG2      = 3'd2;
    localparam logic [2:0] CFG_KEY_ENABLE    = 3'd3;
    localparam logic [2:0] CFG_KEY_COLOR     = 3'd4;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd6;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] byte_addr;
        logic [7:0]        byte_data;
        logic [15:0]       dest_x;
        logic [15:0]       dest_y;
        logic              use_rect;
        logic [5:0]        rect_x;
        logic [5:0]        rect_y;
        logic [6:0]        rect_w;
        logic [6:0]        rect_h;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic [7:0]  color;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [6:0]  tex_width;
        logic [6:0]  tex_height;
        logic [1:0]  bpp_log2;
        logic        key_enable;
        logic [7:0]  key_color;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_ROW   = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              ok;
        logic [ADDR_W-1:0] byte_addr;
        logic [7:0]        byte_data;
        logic [15:0]       dest_x;
        logic [15:0]       dest_y;
        logic [5:0]        col_start;
        logic [6:0]        col_end;
        logic [5:0]        row_start;
        logic [6:0]        row_end;
    } entry_t;

    function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] lim);
        return (v < lim) ? v : lim;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pptb_front.sv
`default_nettype none

module pptb_front
    import pptb_pkg::*;
(
    input  wire logic   accept,
    input  wire item_t  item,
    input  wire cfg_t   cfg,
    output logic        push,
    output entry_t      entry
);

    logic [6:0] eff_w;
    logic [6:0] eff_h;
    logic [5:0] rx;
    logic [5:0] ry;
    logic [6:0] rw;
    logic [6:0] rh;
    logic [7:0] sum_x;
    logic [7:0] sum_y;

    always_comb
    begin
        eff_w = clamp7(cfg.tex_width, 7'(TEX_MAX_W));
        eff_h = clamp7(cfg.tex_height, 7'(TEX_MAX_H));
        if (item.use_rect)
        begin
            rx = item.rect_x;
            ry = item.rect_y;
            rw = item.rect_w;
            rh = item.rect_h;
        end
        else
        begin
            rx = 6'd0;
            ry = 6'd0;
            rw = eff_w;
            rh = eff_h;
        end
        sum_x = {2'b00, rx} + {1'b0, rw};
        sum_y = {2'b00, ry} + {1'b0, rh};

        entry.op        = OP_LOAD;
        entry.ok        = (sum_x <= {1'b0, eff_w}) && (sum_y <= {1'b0, eff_h});
        entry.byte_addr = item.byte_addr;
        entry.byte_data = item.byte_data;
        entry.dest_x    = item.dest_x;
        entry.dest_y    = item.dest_y;
        entry.col_start = rx;
        entry.col_end   = sum_x[6:0];
        entry.row_start = ry;
        entry.row_end   = sum_y[6:0];

        // unknown command codes are dropped here and never reach the back end
        unique case (item.cmd)
            CMD_LOAD:
            begin
                entry.op = OP_LOAD;
                push     = accept;
            end
            CMD_START:
            begin
                entry.op = OP_START;
                push     = accept;
            end
            CMD_ROW:
            begin
                entry.op = OP_ROW;
                push     = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/pptb_queue.sv
`default_nettype none

module pptb_queue
    import pptb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t din,
    input  wire logic   pop,
    output entry_t      dout,
    output logic        valid,
    output logic        full
);

    entry_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign dout  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pptb_back.sv
`default_nettype none

module pptb_back
    import pptb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   q_valid,
    input  wire entry_t head,
    output logic        pop,
    output res_t        result,
    output logic        strobe
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROW  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    logic [7:0] texture_store [TEX_BYTES];

    state_t      state_reg,      state_next;
    logic        active_reg,     active_next;
    logic [6:0]  cur_row_reg,    cur_row_next;
    logic [6:0]  end_row_reg,    end_row_next;
    logic [5:0]  col_start_reg,  col_start_next;
    logic [6:0]  col_end_reg,    col_end_next;
    logic [15:0] origin_x_reg,   origin_x_next;
    logic [15:0] cur_y_reg,      cur_y_next;
    logic [13:0] base_reg,       base_next;
    logic [6:0]  x_reg,          x_next;
    logic [16:0] sx_reg,         sx_next;
    logic        rd_valid_reg,   rd_valid_next;
    logic [2:0]  rd_pos_reg,     rd_pos_next;
    logic [15:0] rd_sx_reg,      rd_sx_next;
    logic        rd_zero_reg,    rd_zero_next;
    logic [7:0]  rd_data_reg;
    logic        pend_valid_reg, pend_valid_next;
    logic [15:0] pend_x_reg,     pend_x_next;
    logic [7:0]  pend_color_reg, pend_color_next;
    res_t        res_reg,        res_next;
    logic        strobe_reg,     strobe_next;

    logic [1:0]  shift;
    logic [6:0]  pitch;
    logic        walk_go;
    logic [13:0] rd_addr;
    logic        mem_rd;
    logic        mem_wr;
    logic [7:0]  byte_v;
    logic [7:0]  pix;
    logic        drawn;

    assign result = res_reg;
    assign strobe = strobe_reg;

    always_comb
    begin
        shift   = 2'd3 - cfg.bpp_log2;
        pitch   = clamp7(cfg.tex_width, 7'(TEX_MAX_W)) >> shift;
        walk_go = (x_reg < col_end_reg) && (sx_reg < {1'b0, cfg.screen_width});
        rd_addr = base_reg + 14'(x_reg >> shift);
        mem_rd  = (state_reg == S_ROW) && walk_go;
        pop     = (state_reg == S_IDLE) && q_valid;
        mem_wr  = pop && (head.op == OP_LOAD);

        // most significant pixel of each byte comes first
        byte_v = rd_zero_reg ? 8'd0 : rd_data_reg;
        unique case (cfg.bpp_log2)
            2'd0:    pix = (byte_v >> ~rd_pos_reg) & 8'h01;
            2'd1:    pix = (byte_v >> {~rd_pos_reg[1:0], 1'b0}) & 8'h03;
            2'd2:    pix = (byte_v >> {~rd_pos_reg[0], 2'b00}) & 8'h0f;
            default: pix = byte_v;
        endcase
        drawn = rd_valid_reg && !(cfg.key_enable && (pix == cfg.key_color));
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        cur_row_next    = cur_row_reg;
        end_row_next    = end_row_reg;
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        origin_x_next   = origin_x_reg;
        cur_y_next      = cur_y_reg;
        base_next       = base_reg;
        x_next          = x_reg;
        sx_next         = sx_reg;
        rd_valid_next   = 1'b0;
        rd_pos_next     = x_reg[2:0];
        rd_sx_next      = sx_reg[15:0];
        rd_zero_next    = (rd_addr >= 14'(TEX_BYTES));
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_color_next = pend_color_reg;
        res_next        = '0;
        strobe_next     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (head.op)
                        OP_START:
                        begin
                            strobe_next   = 1'b1;
                            res_next.last = 1'b1;
                            if (head.ok)
                            begin
                                active_next    = 1'b1;
                                col_start_next = head.col_start;
                                col_end_next   = head.col_end;
                                cur_row_next   = {1'b0, head.row_start};
                                end_row_next   = head.row_end;
                                origin_x_next  = head.dest_x;
                                cur_y_next     = head.dest_y;
                                res_next.kind  = KIND_ACCEPTED;
                            end
                            else
                            begin
                                active_next   = 1'b0;
                                res_next.kind = KIND_REJECTED;
                            end
                        end
                        OP_ROW:
                        begin
                            if (!active_reg || (cur_row_reg >= end_row_reg)
                                || (cur_y_reg >= cfg.screen_height))
                            begin
                                active_next   = 1'b0;
                                strobe_next   = 1'b1;
                                res_next.kind = KIND_FINISHED;
                                res_next.last = 1'b1;
                            end
                            else
                            begin
                                base_next       = 14'(cur_row_reg) * 14'(pitch);
                                x_next          = {1'b0, col_start_reg};
                                sx_next         = {1'b0, origin_x_reg};
                                pend_valid_next = 1'b0;
                                state_next      = S_ROW;
                            end
                        end
                        default:
                        begin
                            // loads are written into the store by the memory block
                        end
                    endcase
                end
            end
            S_ROW:
            begin
                if (walk_go)
                begin
                    x_next        = x_reg + 1'b1;
                    sx_next       = sx_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
                // hold one drawn pixel back so the final one can carry last
                if (drawn)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next       = 1'b1;
                        res_next.kind     = KIND_PIXEL;
                        res_next.screen_x = pend_x_reg;
                        res_next.screen_y = cur_y_reg;
                        res_next.color    = pend_color_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_x_next     = rd_sx_reg;
                    pend_color_next = pix;
                end
            end
            S_FIN:
            begin
                strobe_next       = 1'b1;
                res_next.last     = 1'b1;
                res_next.screen_y = cur_y_reg;
                if (pend_valid_reg)
                begin
                    res_next.kind     = KIND_PIXEL;
                    res_next.screen_x = pend_x_reg;
                    res_next.color    = pend_color_reg;
                end
                else
                begin
                    res_next.kind = KIND_EMPTY;
                end
                pend_valid_next = 1'b0;
                cur_row_next    = cur_row_reg + 1'b1;
                cur_y_next      = cur_y_reg + 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= 1'b0;
            cur_row_reg    <= '0;
            end_row_reg    <= '0;
            col_start_reg  <= '0;
            col_end_reg    <= '0;
            origin_x_reg   <= '0;
            cur_y_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            cur_row_reg    <= cur_row_next;
            end_row_reg    <= end_row_next;
            col_start_reg  <= col_start_next;
            col_end_reg    <= col_end_next;
            origin_x_reg   <= origin_x_next;
            cur_y_reg      <= cur_y_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        x_reg          <= x_next;
        sx_reg         <= sx_next;
        rd_pos_reg     <= rd_pos_next;
        rd_sx_reg      <= rd_sx_next;
        rd_zero_reg    <= rd_zero_next;
        pend_x_reg     <= pend_x_next;
        pend_color_reg <= pend_color_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            texture_store[head.byte_addr] <= head.byte_data;
        end
        if (mem_rd)
        begin
            rd_data_reg <= texture_store[rd_addr[ADDR_W-1:0]];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/packed_pixel_texture_blit_unit.sv
// Packed-pixel texture blitter. A command is taken when start is high and busy is low; busy
// rises only while the two-entry command queue between the decoder and the execution engine
// is full. In the engine a load or start command is handled in the idle state, and a row
// command walks the source columns until the row ends or clips at the screen width, then
// passes through a finish state back to idle. The texture store has one read port and the
// row walk reads one pixel per cycle from it. Each result is on result for exactly one cycle
// with strobe high and cannot be held off; pixel writes of a row appear at most one per
// cycle, the row's final result carrying last. Configuration writes (cfg_ready is always
// high) must only be made while no command is queued or executing.
`default_nettype none

module packed_pixel_texture_blit_unit
    import pptb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output res_t             result,
    output logic             strobe,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   accept;
    logic   push;
    entry_t entry;
    entry_t head;
    logic   q_valid;
    logic   q_full;
    logic   pop;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tex_width     <= 7'd64;
            cfg_reg.tex_height    <= 7'd64;
            cfg_reg.bpp_log2      <= 2'd3;
            cfg_reg.key_enable    <= 1'b0;
            cfg_reg.key_color     <= 8'd0;
            cfg_reg.screen_width  <= 16'd640;
            cfg_reg.screen_height <= 16'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEX_WIDTH:     cfg_reg.tex_width     <= cfg_data[6:0];
                CFG_TEX_HEIGHT:    cfg_reg.tex_height    <= cfg_data[6:0];
                CFG_BPP_LOG2:      cfg_reg.bpp_log2      <= cfg_data[1:0];
                CFG_KEY_ENABLE:    cfg_reg.key_enable    <= cfg_data[0];
                CFG_KEY_COLOR:     cfg_reg.key_color     <= cfg_data[7:0];
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pptb_front u_front (
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .push   (push),
        .entry  (entry)
    );

    pptb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (entry),
        .pop    (pop),
        .dout   (head),
        .valid  (q_valid),
        .full   (q_full)
    );

    pptb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
    import pptb_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;   // unused opcode, dropped by the block
    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASE_ITEMS = 55;
    // bytes loaded up front; texture geometry is kept so rows never read past them
    localparam int FILL_BYTES = 192;

    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        item_t       it;
        bit          typed;
        logic [2:0]  kind;
    } dir_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    item_t       item = '0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        busy;
    logic        strobe;
    logic        cfg_ready;
    res_t        result;

    // shadow copy of the blitter
    cfg_t        regs;
    logic [7:0]  tex_mem [TEX_BYTES];
    bit          blit_on;
    bit          blit_over;
    int unsigned src_row, src_row_end, col_first, col_stop;
    logic [15:0] org_x, dst_row;

    res_t        blit_results[$];
    res_t        want;
    dir_row_t    dir_tab[$];
    int          err_count = 0;
    int          item_count = 0;
    int          idle_pct = 24;

    packed_pixel_texture_blit_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .result    (result),
        .strobe    (strobe),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned eff_width();
        return (regs.tex_width < TEX_MAX_W) ? regs.tex_width : TEX_MAX_W;
    endfunction

    function automatic int unsigned eff_height();
        return (regs.tex_height < TEX_MAX_H) ? regs.tex_height : TEX_MAX_H;
    endfunction

    task automatic blit_step(input item_t it, output res_t outs[$]);
        int unsigned ew, eh, rx, ry, rw, rh;
        int unsigned shift, bpp, ppb, pmask, pitch, x, sx, addr, pos, b, pix;
        res_t r;
        outs.delete();
        ew = eff_width();
        eh = eff_height();
        r = '0;
        case (it.cmd)
            CMD_LOAD:
            begin
                tex_mem[it.byte_addr] = it.byte_data;
            end
            CMD_START:
            begin
                rx = 0;
                ry = 0;
                rw = ew;
                rh = eh;
                if (it.use_rect)
                begin
                    rx = it.rect_x;
                    ry = it.rect_y;
                    rw = it.rect_w;
                    rh = it.rect_h;
                end
                if (rx + rw > ew || ry + rh > eh)
                begin
                    blit_on = 1'b0;
                    blit_over = 1'b1;
                    r.kind = KIND_REJECTED;
                end
                else
                begin
                    blit_on = 1'b1;
                    blit_over = 1'b0;
                    col_first = rx;
                    col_stop = rx + rw;
                    src_row = ry;
                    src_row_end = ry + rh;
                    org_x = it.dest_x;
                    dst_row = it.dest_y;
                    r.kind = KIND_ACCEPTED;
                end
                outs.push_back(r);
            end
            CMD_ROW:
            begin
                if (!blit_on || src_row >= src_row_end || dst_row >= regs.screen_height)
                begin
                    blit_on = 1'b0;
                    blit_over = 1'b1;
                    r.kind = KIND_FINISHED;
                    outs.push_back(r);
                end
                else
                begin
                    shift = 3 - regs.bpp_log2;
                    bpp = 1 << regs.bpp_log2;
                    ppb = 1 << shift;
                    pmask = (1 << bpp) - 1;
                    pitch = ew >> shift;
                    for (x = col_first; x < col_stop && outs.size() < 64; x++)
                    begin
                        // screen column is taken without 16-bit wrap
                        sx = org_x + (x - col_first);
                        if (sx >= regs.screen_width)
                            break;
                        addr = src_row * pitch + (x >> shift);
                        b = (addr < TEX_BYTES) ? tex_mem[addr] : 0;
                        pos = x & (ppb - 1);
                        pix = (b >> (bpp * (ppb - pos - 1))) & pmask;
                        if (!regs.key_enable || pix[7:0] != regs.key_color)
                        begin
                            r = '0;
                            r.kind = KIND_PIXEL;
                            r.screen_x = sx[15:0];
                            r.screen_y = dst_row;
                            r.color = pix[7:0];
                            outs.push_back(r);
                        end
                    end
                    if (outs.size() == 0)
                    begin
                        r = '0;
                        r.kind = KIND_EMPTY;
                        r.screen_y = dst_row;
                        outs.push_back(r);
                    end
                    src_row = (src_row + 1) & 7'h7F;
                    dst_row = dst_row + 16'd1;
                end
            end
            default: ;
        endcase
        if (outs.size() != 0)
        begin
            r = outs.pop_back();
            r.last = 1'b1;
            outs.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
        begin
            if (blit_results.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected result: expected none,", $time);
                $display("%0t            actual kind=%0d x=%0d y=%0d color=%0d last=%0d",
                         $time, result.kind, result.screen_x, result.screen_y,
                         result.color, result.last);
            end
            else
            begin
                want = blit_results.pop_front();
                if (result.kind !== want.kind || result.screen_x !== want.screen_x ||
                    result.screen_y !== want.screen_y || result.color !== want.color ||
                    result.last !== want.last)
                begin
                    err_count++;
                    $display("%0t mismatch: expected kind=%0d x=%0d y=%0d color=%0d last=%0d",
                             $time, want.kind, want.screen_x, want.screen_y, want.color,
                             want.last);
                    $display("%0t            actual kind=%0d x=%0d y=%0d color=%0d last=%0d",
                             $time, result.kind, result.screen_x, result.screen_y,
                             result.color, result.last);
                end
            end
        end
    end

    task automatic send(input item_t it, input bit typed, input logic [2:0] kind);
        res_t outs[$];
        res_t r;
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transaction taken at this edge
        blit_step(it, outs);
        if (typed)
        begin
            r = '0;
            r.kind = kind;
            r.last = 1'b1;
            blit_results.push_back(r);
        end
        else
        begin
            foreach (outs[k])
                blit_results.push_back(outs[k]);
        end
        if (it.cmd != CMD_NONE)
            item_count++;
    endtask

    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < idle_pct)
            hold_off(($urandom_range(0, 5) == 0) ? $urandom_range(1, 80)
                                                   : $urandom_range(1, 4));
    endtask

    task automatic issue(input item_t it);
        maybe_idle();
        send(it, 1'b0, KIND_PIXEL);
    endtask

    // hold the sender until every queued result is out and the engine has gone quiet
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (blit_results.size() != 0)
            @(negedge clk);
        repeat (24)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TEX_WIDTH:     regs.tex_width = val[6:0];
            CFG_TEX_HEIGHT:    regs.tex_height = val[6:0];
            CFG_BPP_LOG2:      regs.bpp_log2 = val[1:0];
            CFG_KEY_ENABLE:    regs.key_enable = val[0];
            CFG_KEY_COLOR:     regs.key_color = val[7:0];
            CFG_SCREEN_WIDTH:  regs.screen_width = val;
            CFG_SCREEN_HEIGHT: regs.screen_height = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits of a narrow register get random junk now and then
    function automatic logic [15:0] junk_bits(input int unsigned val, input int w);
        logic [15:0] mask;
        mask = 16'((32'd1 << w) - 1);
        return (16'(val) & mask)
               | (($urandom_range(0, 3) == 0) ? (16'($urandom) & ~mask) : 16'd0);
    endfunction

    function automatic logic [7:0] fill_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic item_t rand_item(input logic [1:0] cmd);
        logic [95:0] raw;
        item_t it;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.cmd = cmd;
        if (cmd == CMD_LOAD)
            it.byte_data = fill_byte();
        return it;
    endfunction

    function automatic item_t mk_cmd(input logic [1:0] cmd);
        item_t it;
        it = '0;
        it.cmd = cmd;
        return it;
    endfunction

    function automatic item_t mk_start(input bit u, input int unsigned rx, input int unsigned ry,
                                       input int unsigned rw, input int unsigned rh,
                                       input int unsigned dx, input int unsigned dy);
        item_t it;
        it = mk_cmd(CMD_START);
        it.use_rect = u;
        it.rect_x = 6'(rx);
        it.rect_y = 6'(ry);
        it.rect_w = 7'(rw);
        it.rect_h = 7'(rh);
        it.dest_x = 16'(dx);
        it.dest_y = 16'(dy);
        return it;
    endfunction

    task automatic dir_op(input item_t it, input bit typed, input logic [2:0] kind);
        dir_row_t d;
        d.is_reg = 1'b0;
        d.reg_idx = '0;
        d.reg_val = '0;
        d.it = it;
        d.typed = typed;
        d.kind = kind;
        dir_tab.push_back(d);
    endtask

    task automatic dir_reg(input logic [2:0] idx, input logic [15:0] val);
        dir_row_t d;
        d.is_reg = 1'b1;
        d.reg_idx = idx;
        d.reg_val = val;
        d.it = '0;
        d.typed = 1'b0;
        d.kind = '0;
        dir_tab.push_back(d);
    endtask

    task automatic build_directed();
        item_t it;
        // no blit active after reset
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        dir_op(mk_start(1, 60, 0, 5, 1, 0, 0), 1'b1, KIND_REJECTED);
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        dir_op(mk_start(1, 0, 63, 1, 2, 0, 0), 1'b1, KIND_REJECTED);
        // whole texture, full 64-pixel row
        dir_op(mk_start(0, 0, 0, 0, 0, 0, 0), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b0, KIND_PIXEL);
        // replaces the blit in progress, zero-width row
        dir_op(mk_start(1, 0, 0, 0, 1, 0, 0), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b0, KIND_PIXEL);
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        dir_op(mk_start(1, 63, 63, 1, 1, 65535, 65535), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        // clip at the right edge of a 640-wide screen
        dir_op(mk_start(1, 8, 2, 16, 1, 630, 10), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b0, KIND_PIXEL);
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        dir_op(mk_cmd(CMD_NONE), 1'b0, KIND_PIXEL);
        it = mk_cmd(CMD_LOAD);
        it.byte_addr = '1;
        it.byte_data = 8'hFF;
        dir_op(it, 1'b0, KIND_PIXEL);
        // 1 bpp with keying
        dir_reg(CFG_BPP_LOG2, 16'd0);
        dir_reg(CFG_KEY_ENABLE, 16'd1);
        dir_reg(CFG_KEY_COLOR, 16'd1);
        dir_op(mk_start(1, 0, 0, 64, 1, 0, 479), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b0, KIND_PIXEL);
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        // key above the 2 bpp range, zero-width screen clips everything
        dir_reg(CFG_BPP_LOG2, 16'd1);
        dir_reg(CFG_KEY_COLOR, 16'd255);
        dir_reg(CFG_SCREEN_WIDTH, 16'd0);
        dir_op(mk_start(0, 0, 0, 0, 0, 0, 0), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b0, KIND_PIXEL);
        // zero screen height ends the blit at once
        dir_reg(CFG_BPP_LOG2, 16'd2);
        dir_reg(CFG_KEY_ENABLE, 16'd0);
        dir_reg(CFG_SCREEN_WIDTH, 16'd65535);
        dir_reg(CFG_SCREEN_HEIGHT, 16'd0);
        dir_op(mk_start(0, 0, 0, 0, 0, 100, 0), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b1, KIND_FINISHED);
        // smallest texture at 4 bpp
        dir_reg(CFG_SCREEN_HEIGHT, 16'd65535);
        dir_reg(CFG_TEX_WIDTH, 16'd1);
        dir_reg(CFG_TEX_HEIGHT, 16'd1);
        dir_op(mk_start(0, 0, 0, 0, 0, 65534, 65534), 1'b1, KIND_ACCEPTED);
        dir_op(mk_cmd(CMD_ROW), 1'b0, KIND_PIXEL);
    endtask

    task automatic random_config();
        int unsigned tw, th, bl, ke, kc, sw, sh;
        int unsigned ew, eh, pitch;
        case ($urandom_range(0, 7))
            0: tw = 1;
            1: tw = 64;
            2: tw = $urandom_range(0, 127);
            default: tw = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 7))
            0: th = 1;
            1: th = 64;
            2: th = $urandom_range(0, 127);
            default: th = $urandom_range(1, 64);
        endcase
        bl = $urandom_range(0, 3);
        // keep every row the texture can hold inside the prefilled bytes
        ew = (tw < TEX_MAX_W) ? tw : TEX_MAX_W;
        eh = (th < TEX_MAX_H) ? th : TEX_MAX_H;
        pitch = ew >> (3 - bl);
        if (pitch != 0 && eh * pitch >= FILL_BYTES)
            th = (FILL_BYTES - 1) / pitch;
        ke = $urandom_range(0, 1);
        case ($urandom_range(0, 5))
            0: kc = 255;
            1: kc = $urandom_range(0, 255);
            default: kc = $urandom_range(0, (1 << (1 << bl)) - 1);
        endcase
        case ($urandom_range(0, 7))
            0: sw = 0;
            1: sw = 65535;
            2: sw = $urandom_range(0, 65535);
            default: sw = $urandom_range(8, 700);
        endcase
        case ($urandom_range(0, 7))
            0: sh = 0;
            1: sh = 65535;
            2: sh = $urandom_range(0, 8);
            3: sh = $urandom_range(0, 65535);
            default: sh = $urandom_range(16, 480);
        endcase
        write_reg(CFG_TEX_WIDTH, junk_bits(tw, 7));
        write_reg(CFG_TEX_HEIGHT, junk_bits(th, 7));
        write_reg(CFG_BPP_LOG2, junk_bits(bl, 2));
        write_reg(CFG_KEY_ENABLE, junk_bits(ke, 1));
        write_reg(CFG_KEY_COLOR, junk_bits(kc, 8));
        write_reg(CFG_SCREEN_WIDTH, 16'(sw));
        write_reg(CFG_SCREEN_HEIGHT, 16'(sh));
    endtask

    task automatic run_blit();
        item_t it;
        int unsigned ew, eh, rx, ry, rw, rh, cap, rows, sw, sh;
        ew = eff_width();
        eh = eff_height();
        sw = regs.screen_width;
        sh = regs.screen_height;
        repeat ($urandom_range(0, 2))
            issue(rand_item(CMD_LOAD));
        it = rand_item(CMD_START);
        case ($urandom_range(0, 9))
            0: it.use_rect = 1'b0;
            1: ;   // raw dice, mostly an overrun
            default:
            begin
                rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ew)
                                                 : $urandom_range(0, (ew < 16) ? ew : 16);
                rx = $urandom_range(0, (ew - rw < 63) ? ew - rw : 63);
                rh = $urandom_range(0, (eh < 6) ? eh : 6);
                ry = $urandom_range(0, (eh - rh < 63) ? eh - rh : 63);
                it.use_rect = 1'b1;
                it.rect_x = 6'(rx);
                it.rect_y = 6'(ry);
                it.rect_w = 7'(rw);
                it.rect_h = 7'(rh);
            end
        endcase
        case ($urandom_range(0, 3))
            0: ;
            1: it.dest_x = 16'((sw >= 16) ? sw - $urandom_range(0, 16) : $urandom_range(0, 16));
            default: it.dest_x = 16'($urandom_range(0, 200));
        endcase
        case ($urandom_range(0, 3))
            0: ;
            1: it.dest_y = 16'((sh >= 4) ? sh - $urandom_range(0, 4) : $urandom_range(0, 4));
            default: it.dest_y = 16'($urandom_range(0, 20));
        endcase
        issue(it);
        cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 80;
        rows = 0;
        while (!blit_over && rows < cap)
        begin
            case ($urandom_range(0, 19))
                0: issue(rand_item(CMD_LOAD));
                1: issue(rand_item(CMD_NONE));
                2: drain();
                default:
                begin
                    issue(rand_item(CMD_ROW));
                    rows++;
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            issue(rand_item(CMD_ROW));
    endtask

    task automatic run_phase(input int pct);
        int first;
        idle_pct = pct;
        first = item_count;
        while (item_count - first < PHASE_ITEMS)
        begin
            drain();
            random_config();
            repeat ($urandom_range(1, 4))
                run_blit();
        end
    endtask

    initial
    begin
        regs = '0;
        regs.tex_width = 7'd64;
        regs.tex_height = 7'd64;
        regs.bpp_log2 = 2'd3;
        regs.screen_width = 16'd640;
        regs.screen_height = 16'd480;
        blit_on = 1'b0;
        blit_over = 1'b1;
        src_row = 0;
        src_row_end = 0;
        col_first = 0;
        col_stop = 0;
        org_x = '0;
        dst_row = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every store byte a row can reach gets written before anything reads it
        for (int a = 0; a < FILL_BYTES; a++)
        begin
            item_t it;
            it = rand_item(CMD_LOAD);
            it.byte_addr = 12'(a);
            issue(it);
        end

        build_directed();
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_reg)
            begin
                drain();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else
            begin
                maybe_idle();
                send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].kind);
            end
        end

        run_phase(24);
        run_phase(71);
        run_phase(0);

        hold_off(1);
        while (blit_results.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (err_count == 0 && blit_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
